FILE: rtl/scs_pkg.sv
// Shared constants, codes and types of the sparse coordinate store.
package scs_pkg;

  localparam int CAPACITY  = 64;
  localparam int MAX_DIM   = 256;
  localparam int ROW_W     = 8;
  localparam int COL_W     = 8;
  localparam int VAL_W     = 32;
  localparam int DIM_W     = 9;
  localparam int STATUS_W  = 2;
  localparam int CFG_IDX_W = 1;
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int IDX_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_READ   = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_RANGE = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [VAL_W-1:0] value;
  } entry_t;

  // Lookup token that walks the chain one cell per cycle.
  typedef struct packed {
    logic             active;
    logic             found;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [VAL_W-1:0] value;
  } probe_t;

endpackage

FILE: rtl/sparse_coordinate_store.sv
// Top level of the sparse coordinate store: control, configuration and result register.
//
//   channel   direction  handshake               payload
//   req       in         req_valid / req_stall   opcode, row_index, col_index, elem_value
//   rsp       out        rsp_valid / rsp_stall   read_value, status
//   cfg       in         cfg_write               cfg_index, cfg_data
//
// An insert, or any item with an index out of range, goes from idle to the hold state.
// An in-range read first passes the scan state: the lookup token crosses the
// chain of CAPACITY cells one cell per clock.
// Reset clears the entry count and restores both dimensions to MAX_DIM.
// A stalled result sits in the output register; the next item is taken in
// meanwhile and its result waits in the pending register.
module sparse_coordinate_store (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              req_valid,
  output logic                              req_stall,
  input  logic                              opcode,
  input  logic        [scs_pkg::ROW_W-1:0]  row_index,
  input  logic        [scs_pkg::COL_W-1:0]  col_index,
  input  logic signed [scs_pkg::VAL_W-1:0]  elem_value,
  output logic                              rsp_valid,
  input  logic                              rsp_stall,
  output logic signed [scs_pkg::VAL_W-1:0]  read_value,
  output logic        [scs_pkg::STATUS_W-1:0] status,
  input  logic                              cfg_write,
  input  logic        [scs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic        [scs_pkg::DIM_W-1:0]  cfg_data
);
  import scs_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_HOLD = 3'b100
  } state_t;

  state_t           state;
  state_t           state_next;
  logic [DIM_W-1:0] num_rows;
  logic [DIM_W-1:0] num_cols;
  logic [CNT_W-1:0] entry_count;
  probe_t           head;
  probe_t           tail;
  entry_t           wr_entry;
  logic [VAL_W-1:0] pend_value;
  status_t          pend_status;
  status_t          imm_status;
  logic [VAL_W-1:0] rsp_value;
  status_t          rsp_status;

  logic accept;
  logic out_free;
  logic in_range;
  logic is_full;
  logic nonzero;
  logic do_insert;
  logic do_read;
  logic load_rsp;

  // Take a new item only when idle; the output register decouples the far side.
  assign req_stall = (state != ST_IDLE);
  assign accept    = req_valid && !req_stall;
  assign out_free  = !rsp_valid || !rsp_stall;

  // The range check comes first and blocks every other effect.
  assign in_range  = ({1'b0, row_index} < num_rows) && ({1'b0, col_index} < num_cols);
  assign is_full   = (entry_count == CNT_W'(CAPACITY));
  assign nonzero   = (elem_value != '0);
  assign do_insert = accept && in_range && (opcode == OP_INSERT) && nonzero && !is_full;
  assign do_read   = accept && in_range && (opcode == OP_READ);
  assign load_rsp  = (state == ST_HOLD) && out_free;

  always_comb begin
    priority if (!in_range) begin
      imm_status = STATUS_RANGE;
    end else if ((opcode == OP_INSERT) && nonzero && is_full) begin
      imm_status = STATUS_FULL;
    end else begin
      imm_status = STATUS_OK;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (do_read) begin
          state_next = ST_SCAN;
        end else if (accept) begin
          state_next = ST_HOLD;
        end
      end
      ST_SCAN: begin
        if (tail.active) begin
          state_next = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control state, configuration and the entry count.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      num_rows    <= DIM_W'(MAX_DIM);
      num_cols    <= DIM_W'(MAX_DIM);
      entry_count <= '0;
      rsp_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        unique case (cfg_index)
          REG_NUM_ROWS: num_rows <= cfg_data;
          REG_NUM_COLS: num_cols <= cfg_data;
          default: ;
        endcase
      end
      if (do_insert) begin
        entry_count <= entry_count + CNT_W'(1);
      end
      if (load_rsp) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Inject the lookup token at the head of the chain for one cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
    end else begin
      head.active <= do_read;
      head.found  <= 1'b0;
      head.row    <= row_index;
      head.col    <= col_index;
      head.value  <= '0;
    end
  end

  // Hold the pending result and the output payload.
  always_ff @(posedge clk) begin
    if (accept && !do_read) begin
      pend_value  <= '0;
      pend_status <= imm_status;
    end else if ((state == ST_SCAN) && tail.active) begin
      pend_value  <= tail.value;
      pend_status <= STATUS_OK;
    end
    if (load_rsp) begin
      rsp_value  <= pend_value;
      rsp_status <= pend_status;
    end
  end

  assign wr_entry.row   = row_index;
  assign wr_entry.col   = col_index;
  assign wr_entry.value = elem_value;

  scs_chain u_chain (
    .clk         (clk),
    .rst         (rst),
    .entry_count (entry_count),
    .wr_en       (do_insert),
    .wr_entry    (wr_entry),
    .probe_in    (head),
    .probe_out   (tail)
  );

  assign read_value = $signed(rsp_value);
  assign status     = rsp_status;

endmodule

FILE: rtl/scs_cell.sv
// One storage cell: holds a single entry and matches the passing lookup token.
module scs_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           live,
  input  logic           wr_en,
  input  scs_pkg::entry_t wr_entry,
  input  scs_pkg::probe_t probe_in,
  output scs_pkg::probe_t probe_out
);
  import scs_pkg::*;

  entry_t entry;
  probe_t probe_next;
  logic   hit;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry <= wr_entry;
    end
  end

  // Only the earliest match counts: a token already found passes unchanged.
  always_comb begin
    hit = probe_in.active && !probe_in.found && live &&
          (entry.row == probe_in.row) && (entry.col == probe_in.col);
    probe_next = probe_in;
    if (hit) begin
      probe_next.found = 1'b1;
      probe_next.value = entry.value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      probe_out <= '0;
    end else begin
      probe_out <= probe_next;
    end
  end

endmodule

FILE: rtl/scs_chain.sv
// Row of storage cells in insertion order, with append decode and live marks.
module scs_chain (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [scs_pkg::CNT_W-1:0] entry_count,
  input  logic                    wr_en,
  input  scs_pkg::entry_t         wr_entry,
  input  scs_pkg::probe_t         probe_in,
  output scs_pkg::probe_t         probe_out
);
  import scs_pkg::*;

  probe_t           link [CAPACITY+1];
  logic [IDX_W-1:0] wr_idx;

  assign wr_idx    = entry_count[IDX_W-1:0];
  assign link[0]   = probe_in;
  assign probe_out = link[CAPACITY];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic cell_live;
    logic cell_wr;

    assign cell_live = (entry_count > CNT_W'(i));
    assign cell_wr   = wr_en && (wr_idx == IDX_W'(i));

    scs_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .live      (cell_live),
      .wr_en     (cell_wr),
      .wr_entry  (wr_entry),
      .probe_in  (link[i]),
      .probe_out (link[i+1])
    );
  end

endmodule

FILE: verif/tb.sv
// Self-checking testbench of the sparse coordinate store: queued stimulus, prediction, checking.
module tb;
  import scs_pkg::*;

  // Cycles with no accepted item on any port before the run is declared hung.
  // The worst correct gap is the long receiver hold plus one full read scan.
  localparam int WATCHDOG_LIMIT = 4000;
  // Length of the receiver hold-off in the pressure phase, in cycles.
  localparam int RSP_HOLD_CYCLES = 300;
  localparam int PRESSURE_PHASE = 3;
  localparam int MAX_PRINTS = 100;

  typedef struct packed {
    logic             op;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [VAL_W-1:0] val;
  } req_item_t;

  typedef struct packed {
    status_t          status;
    logic [VAL_W-1:0] value;
  } rsp_t;

  // Clock, reset and block ports; every input starts at a known value.
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  logic opcode = OP_INSERT;
  logic [ROW_W-1:0] row_index = '0;
  logic [COL_W-1:0] col_index = '0;
  logic signed [VAL_W-1:0] elem_value = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  logic signed [VAL_W-1:0] read_value;
  logic [STATUS_W-1:0] status;
  logic cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_NUM_ROWS;
  logic [DIM_W-1:0] cfg_data = '0;

  sparse_coordinate_store u_top (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .opcode     (opcode),
    .row_index  (row_index),
    .col_index  (col_index),
    .elem_value (elem_value),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .read_value (read_value),
    .status     (status),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Shadow copy of the store: dimensions, entries in insertion order, count.
  logic [DIM_W-1:0] mdl_rows = DIM_W'(MAX_DIM);
  logic [DIM_W-1:0] mdl_cols = DIM_W'(MAX_DIM);
  entry_t           mdl_entries [CAPACITY];
  int               mdl_count = 0;

  req_item_t        pending_items [$];
  rsp_t             expected_rsp_q [$];
  logic [15:0]      stored_coords [$];   // first 96 queued insert coordinates, for read hits

  int mismatch_count = 0;
  int send_idle_pct = 20;
  int recv_idle_pct = 20;
  int phase_id = 0;

  // Apply one item to the shadow store and return the result it must give.
  // The range test comes first; a zero insert stores nothing, even when full;
  // a read returns the earliest entry at the coordinates.
  function automatic rsp_t coo_apply(logic op, logic [ROW_W-1:0] r, logic [COL_W-1:0] c,
                                     logic [VAL_W-1:0] v);
    rsp_t res;
    res.status = STATUS_OK;
    res.value = '0;
    if ({1'b0, r} >= mdl_rows || {1'b0, c} >= mdl_cols) begin
      res.status = STATUS_RANGE;
    end else if (op == OP_INSERT) begin
      if (v != '0) begin
        if (mdl_count >= CAPACITY) begin
          res.status = STATUS_FULL;
        end else begin
          mdl_entries[mdl_count[IDX_W-1:0]] = '{row: r, col: c, value: v};
          mdl_count++;
        end
      end
    end else begin
      for (int i = 0; i < mdl_count; i++) begin
        if (mdl_entries[i[IDX_W-1:0]].row == r && mdl_entries[i[IDX_W-1:0]].col == c) begin
          res.value = mdl_entries[i[IDX_W-1:0]].value;
          break;
        end
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [VAL_W-1:0] got,
                                 input logic [VAL_W-1:0] want);
    if (mismatch_count < MAX_PRINTS)
      $display("%0t: mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    mismatch_count++;
  endtask

  // Driver: hold an item until it is taken, then pick the next one from the
  // queue or stay idle at random. Predict each item as it is taken.
  logic      drv_busy;
  req_item_t drv_next;

  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      drv_busy = req_valid;
      if (req_valid && !req_stall) begin
        expected_rsp_q.push_back(coo_apply(opcode, row_index, col_index, elem_value));
        drv_busy = 1'b0;
      end
      if (!drv_busy) begin
        if (pending_items.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          drv_next = pending_items.pop_front();
          req_valid  <= 1'b1;
          opcode     <= drv_next.op;
          row_index  <= drv_next.row;
          col_index  <= drv_next.col;
          elem_value <= drv_next.val;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each taken result against the oldest expectation, then
  // decide the stall for the next cycle. In the pressure phase hold off once
  // for a long stretch so the block backs up and stalls its input.
  rsp_t mon_want;
  int   hold_left = 0;
  logic hold_done = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (expected_rsp_q.size() == 0) begin
          report_mismatch("unexpected result", read_value, '0);
        end else begin
          mon_want = expected_rsp_q.pop_front();
          if (read_value !== mon_want.value)
            report_mismatch("read_value", read_value, mon_want.value);
          if (status !== mon_want.status)
            report_mismatch("status", VAL_W'(status), VAL_W'(mon_want.status));
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_stall <= 1'b1;
      end else if (phase_id == PRESSURE_PHASE && !hold_done) begin
        hold_left = RSP_HOLD_CYCLES - 1;
        hold_done = 1'b1;
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  // Watchdog: count cycles in which nothing moves on any port.
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || cfg_write) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  task automatic push_item(input logic op, input int r, input int c, input logic [VAL_W-1:0] v);
    req_item_t it;
    it.op = op;
    it.row = r[ROW_W-1:0];
    it.col = c[COL_W-1:0];
    it.val = v;
    if (op == OP_INSERT && stored_coords.size() < 96)
      stored_coords.push_back({it.row, it.col});
    pending_items.push_back(it);
  endtask

  // Build one random item under the current dimensions: mostly well-formed
  // inserts and reads aimed at stored coordinates, plus grid edges and noise.
  task automatic push_random_item(input int insert_pct);
    int lim_r;
    int lim_c;
    int pick;
    int r;
    int c;
    logic [15:0] rc;
    logic [VAL_W-1:0] v;
    logic op;
    lim_r = (mdl_rows > MAX_DIM) ? MAX_DIM : int'(mdl_rows);
    lim_c = (mdl_cols > MAX_DIM) ? MAX_DIM : int'(mdl_cols);
    op = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_READ;
    pick = $urandom_range(0, 99);
    if (pick < 10 || lim_r == 0 || lim_c == 0) begin
      // anywhere in the 8-bit space, out of range included
      r = $urandom_range(0, 255);
      c = $urandom_range(0, 255);
    end else if (pick < 22) begin
      // last valid index or first invalid one
      r = (lim_r < MAX_DIM && $urandom_range(0, 1)) ? lim_r : lim_r - 1;
      c = (lim_c < MAX_DIM && $urandom_range(0, 1)) ? lim_c : lim_c - 1;
    end else if (pick < 65 && stored_coords.size() > 0) begin
      // revisit a stored coordinate: a read hit or a duplicate insert
      rc = stored_coords[$urandom_range(0, stored_coords.size() - 1)];
      r = int'(rc[15:8]);
      c = int'(rc[7:0]);
    end else begin
      r = $urandom_range(0, lim_r - 1);
      c = $urandom_range(0, lim_c - 1);
    end
    case ($urandom_range(0, 9))
      0: v = '0;
      1: v = 32'h7FFF_FFFF;
      2: v = 32'h8000_0000;
      3: v = 32'hFFFF_FFFF;
      default: v = $urandom;
    endcase
    push_item(op, r, c, v);
  endtask

  // Wait until nothing is queued, offered or outstanding.
  task automatic settle();
    while (pending_items.size() > 0 || req_valid || expected_rsp_q.size() > 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int data);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data[DIM_W-1:0];
    if (idx == REG_NUM_ROWS) mdl_rows = data[DIM_W-1:0];
    else mdl_cols = data[DIM_W-1:0];
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // One random phase: drain, set both dimensions, then queue the items.
  task automatic random_phase(input int rows, input int cols, input int n, input int insert_pct,
                              input int send_idle, input int recv_idle);
    settle();
    write_reg(REG_NUM_ROWS, rows);
    write_reg(REG_NUM_COLS, cols);
    @(negedge clk);
    send_idle_pct = send_idle;
    recv_idle_pct = recv_idle;
    phase_id++;
    repeat (n) push_random_item(insert_pct);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part under the reset dimensions: empty-store read, extreme
    // values and corners, zero insert, duplicate coordinates, read misses.
    push_item(OP_READ,     0,   0,   32'h0000_0000);
    push_item(OP_INSERT,   0,   0,   32'h7FFF_FFFF);
    push_item(OP_INSERT,   255, 255, 32'h8000_0000);
    push_item(OP_INSERT,   1,   1,   32'h0000_0000);
    push_item(OP_READ,     1,   1,   32'h1234_5678);
    push_item(OP_READ,     0,   0,   32'hFFFF_FFFF);
    push_item(OP_READ,     255, 255, 32'h0000_0000);
    push_item(OP_INSERT,   0,   0,   32'hFFFF_FFFF);
    push_item(OP_READ,     0,   0,   32'h0000_0000);
    push_item(OP_INSERT,   0,   255, 32'h0000_0001);
    push_item(OP_INSERT,   255, 0,   32'h5555_5555);
    push_item(OP_READ,     0,   255, 32'h0000_0000);
    push_item(OP_READ,     255, 0,   32'hAAAA_AAAA);
    push_item(OP_READ,     255, 254, 32'h0000_0000);
    push_item(OP_READ,     254, 255, 32'h0000_0000);
    push_item(OP_INSERT,   128, 127, 32'hAAAA_AAAA);
    push_item(OP_READ,     128, 127, 32'h0000_0000);

    // Small grid: many duplicates and out-of-range edges.
    random_phase(4, 4, 120, 40, 20, 20);
    // Single column, no idling on either side.
    random_phase(256, 1, 80, 40, 0, 0);
    // All-ones registers, insert-heavy, long receiver hold-off.
    random_phase(511, 511, 120, 80, 0, 20);
    // Zero rows: every index is out of range.
    random_phase(0, 200, 30, 50, 20, 20);
    // One row, full width.
    random_phase(1, 256, 60, 40, 20, 20);
    random_phase(200, 37, 150, 35, 20, 20);
    random_phase(256, 256, 170, 35, 20, 20);

    settle();
    repeat (CAPACITY + 8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/scs_pkg.sv
rtl/scs_cell.sv
rtl/scs_chain.sv
rtl/sparse_coordinate_store.sv
verif/tb.sv
